// ----- hw/rtl/gaussian_rejection_sampler_assert.svh -----
// ---------------------------------------------------------------------------
// Gaussian rejection sampler assertion macros
// Clocked assertion shorthands shared by the sampler modules.
// ---------------------------------------------------------------------------
`ifndef GAUSSIAN_REJECTION_SAMPLER_ASSERT_SVH
`define GAUSSIAN_REJECTION_SAMPLER_ASSERT_SVH

// Property checked on every rising edge of clk while not in reset.
`define GRS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never hold outside reset.
`define GRS_ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/grs_pkg.sv -----
// ---------------------------------------------------------------------------
// Gaussian rejection sampler package
// Widths, constants, controller types and the exponential lookup table.
// ---------------------------------------------------------------------------
`default_nettype none

package grs_pkg;

	localparam int SAMPLE_WIDTH = 16;
	localparam int EXP_ENTRIES  = 256;
	localparam int EXP_BITS     = $clog2(EXP_ENTRIES);
	localparam int EXP_IDX_W    = EXP_BITS + 1;

	localparam int SEED_W      = 31;
	localparam int COUNT_W     = 24;
	localparam int ENV_W       = 32;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 31;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = ((SAMPLE_WIDTH + ENV_W + 7) / 8) * 8;

	localparam logic [30:0] PM_MOD    = 31'h7FFF_FFFF;
	localparam logic [14:0] PM_MUL    = 15'd16807;
	localparam logic [30:0] ONE_Q30   = 31'h4000_0000;
	localparam logic [62:0] ENV_LIMIT = 63'd1398493785088105381;
	localparam logic [31:0] RECIP_10  = 32'hCCCC_CCCD;

	localparam logic [SEED_W-1:0]  SEED_RESET  = SEED_W'(1);
	localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(50000);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEED         = 1'b0,
		REG_SAMPLE_COUNT = 1'b1
	} grs_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GEN1,
		ST_GEN2,
		ST_GEN3,
		ST_MUL,
		ST_ENV,
		ST_INTERP,
		ST_DECIDE
	} grs_state_t;

	typedef struct packed {
		logic take;
		logic gen1;
		logic gen2;
		logic gen3;
		logic mul;
		logic env;
		logic interp;
		logic decide;
	} grs_cmd_t;

	typedef struct packed {
		logic run_trial;
		logic accept;
		logic out_busy;
	} grs_sts_t;

	typedef logic [30:0] exp_tab_t [0:EXP_ENTRIES];

	// One step of the generator: 16807 * s modulo 2^31-1 by folding the high bits.
	function automatic logic [30:0] pm_next(input logic [30:0] s);
		logic [45:0] p;
		logic [31:0] r;
		p = 46'(s) * 46'(PM_MUL);
		r = 32'(p[30:0]) + 32'(p[45:31]);
		if (r >= 32'(PM_MOD)) begin
			r = r - 32'(PM_MOD);
		end
		return r[30:0];
	endfunction

	function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] p;
		p = (a * b) >> 30;
		return p;
	endfunction

	// exp(-k/(2E)) in Q.30 from a truncated alternating series through the twentieth power.
	function automatic logic [30:0] exp_entry(input int unsigned k);
		logic [63:0] t;
		logic [63:0] term;
		longint      sum;
		t    = (64'(k) << 29) / EXP_ENTRIES;
		term = 64'(ONE_Q30);
		sum  = longint'(ONE_Q30);
		term = mulq(term, t);           sum = sum - longint'(term);
		term = mulq(term, t) / 64'd2;   sum = sum + longint'(term);
		term = mulq(term, t) / 64'd3;   sum = sum - longint'(term);
		term = mulq(term, t) / 64'd4;   sum = sum + longint'(term);
		term = mulq(term, t) / 64'd5;   sum = sum - longint'(term);
		term = mulq(term, t) / 64'd6;   sum = sum + longint'(term);
		term = mulq(term, t) / 64'd7;   sum = sum - longint'(term);
		term = mulq(term, t) / 64'd8;   sum = sum + longint'(term);
		term = mulq(term, t) / 64'd9;   sum = sum - longint'(term);
		term = mulq(term, t) / 64'd10;  sum = sum + longint'(term);
		term = mulq(term, t) / 64'd11;  sum = sum - longint'(term);
		term = mulq(term, t) / 64'd12;  sum = sum + longint'(term);
		term = mulq(term, t) / 64'd13;  sum = sum - longint'(term);
		term = mulq(term, t) / 64'd14;  sum = sum + longint'(term);
		term = mulq(term, t) / 64'd15;  sum = sum - longint'(term);
		term = mulq(term, t) / 64'd16;  sum = sum + longint'(term);
		term = mulq(term, t) / 64'd17;  sum = sum - longint'(term);
		term = mulq(term, t) / 64'd18;  sum = sum + longint'(term);
		term = mulq(term, t) / 64'd19;  sum = sum - longint'(term);
		term = mulq(term, t) / 64'd20;  sum = sum + longint'(term);
		if (sum < 0) begin
			sum = 0;
		end
		if (sum > longint'(ONE_Q30)) begin
			sum = longint'(ONE_Q30);
		end
		return 31'(sum);
	endfunction

	function automatic exp_tab_t build_exp_tab();
		exp_tab_t tab;
		for (int k = 0; k <= EXP_ENTRIES; k++) begin
			tab[k] = exp_entry(k);
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage

`default_nettype wire

// ----- hw/rtl/grs_ctrl.sv -----
// ---------------------------------------------------------------------------
// Sampler controller
// Sequences one trial through generator steps, multiplies, tests and output.
// ---------------------------------------------------------------------------
`default_nettype none

`include "gaussian_rejection_sampler_assert.svh"

module grs_ctrl
	import grs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	input  wire grs_sts_t sts,
	output grs_cmd_t      cmd
);

	grs_state_t state_q;
	grs_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.take = 1'b1;
					if (sts.run_trial) begin
						state_d = ST_GEN1;
					end
				end
			end
			ST_GEN1: begin
				cmd.gen1 = 1'b1;
				state_d  = ST_GEN2;
			end
			ST_GEN2: begin
				cmd.gen2 = 1'b1;
				state_d  = ST_GEN3;
			end
			ST_GEN3: begin
				cmd.gen3 = 1'b1;
				state_d  = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ENV;
			end
			ST_ENV: begin
				cmd.env = 1'b1;
				state_d = ST_INTERP;
			end
			ST_INTERP: begin
				cmd.interp = 1'b1;
				state_d    = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (!(sts.accept && sts.out_busy)) begin
					cmd.decide = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	`GRS_ASSERT(a_decide_holds_on_stall,
		(state_q == ST_DECIDE && sts.accept && sts.out_busy) |=> state_q == ST_DECIDE,
		"accepted trial left the decide step while the output was occupied")
	`GRS_ASSERT(a_finished_stays_idle,
		(state_q == ST_IDLE && s_tvalid && !sts.run_trial) |=> state_q == ST_IDLE,
		"a trial started after the sample run had finished")
	`GRS_ASSERT_NEVER(a_decide_into_busy,
		cmd.decide && sts.accept && sts.out_busy,
		"a result was loaded over one not yet taken")

endmodule

`default_nettype wire

// ----- hw/rtl/grs_datapath.sv -----
// ---------------------------------------------------------------------------
// Sampler datapath
// Generator, fixed-point trial arithmetic, counters and output register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "gaussian_rejection_sampler_assert.svh"

module grs_datapath
	import grs_pkg::*;
(
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    restart,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_DATA_W-1:0]   cfg_data,
	input  wire grs_cmd_t                cmd,
	output grs_sts_t                     sts,
	output logic                         m_tvalid,
	input  wire logic                    m_tready,
	output logic [SAMPLE_WIDTH-1:0]      sample,
	output logic                         last_sample,
	output logic [ENV_W-1:0]             envelope_trials
);

	logic [SEED_W-1:0]  seed_q;
	logic [COUNT_W-1:0] count_cfg_q;
	logic [30:0]        gen_q;
	logic [COUNT_W-1:0] produced_q;
	logic [ENV_W-1:0]   env_cnt_q;
	logic               finished_q;
	logic               valid_q;

	logic [30:0] g1_q;
	logic [30:0] g2_q;
	logic [30:0] mag_q;
	logic [61:0] sq_q;
	logic [63:0] dq_q;
	logic [30:0] x2_q;
	logic [61:0] x4p_q;
	logic [30:0] y30_q;
	logic [62:0] envp_q;
	logic [30:0] a_q;
	logic [30:0] b_q;
	logic [29:0] f_q;
	logic        pass_env_q;
	logic        down_q;
	logic [60:0] ip_q;

	logic [SAMPLE_WIDTH-1:0] sample_q;
	logic                    last_q;
	logic [ENV_W-1:0]        env_out_q;

	logic [30:0]          gen_next;
	logic [29:0]          v30;
	logic [31:0]          three_v;
	logic [30:0]          x2;
	logic [30:0]          x4;
	logic [EXP_IDX_W-1:0] idx;
	logic [EXP_IDX_W-1:0] idx_p1;
	logic [30:0]          a_next;
	logic [30:0]          b_next;
	logic [30:0]          diff;
	logic [30:0]          e_val;
	logic                 accept;
	logic [ENV_W-1:0]     env_next;
	logic [COUNT_W-1:0]   prod_next;
	logic                 last_now;
	logic [31:0]          ux_ext;
	logic [SAMPLE_WIDTH-1:0] samp_raw;

	assign gen_next = pm_next(gen_q);
	assign v30      = g2_q[30:1];
	assign three_v  = {1'b0, v30, 1'b0} + {2'b00, v30};
	assign x2       = sq_q[60:30];
	assign x4       = x4p_q[60:30];

	assign idx    = x2_q[30 -: EXP_IDX_W];
	assign idx_p1 = idx + EXP_IDX_W'(1);

	always_comb begin
		if (idx >= EXP_IDX_W'(EXP_ENTRIES)) begin
			a_next = EXP_TAB[EXP_ENTRIES];
			b_next = EXP_TAB[EXP_ENTRIES];
		end else begin
			a_next = EXP_TAB[idx];
			b_next = EXP_TAB[idx_p1];
		end
	end

	assign diff  = (a_q >= b_q) ? (a_q - b_q) : (b_q - a_q);
	assign e_val = down_q ? (a_q - ip_q[60:30]) : (a_q + ip_q[60:30]);
	assign accept = pass_env_q && (y30_q <= e_val);

	assign env_next  = (pass_env_q && (env_cnt_q != '1)) ? env_cnt_q + ENV_W'(1) : env_cnt_q;
	assign prod_next = produced_q + COUNT_W'(1);
	assign last_now  = (prod_next == count_cfg_q);

	// x + 1 in Q.30 equals the generator value, so the sample is its top bits less one.
	assign ux_ext   = {g1_q, 1'b0};
	assign samp_raw = ux_ext[31 -: SAMPLE_WIDTH];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= SEED_RESET;
			count_cfg_q <= COUNT_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_SEED) begin
				seed_q <= cfg_data[SEED_W-1:0];
			end else if (cfg_index == REG_SAMPLE_COUNT) begin
				count_cfg_q <= cfg_data[COUNT_W-1:0];
			end
		end
	end

	// Generator and run state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gen_q      <= 31'(SEED_RESET);
			produced_q <= '0;
			env_cnt_q  <= '0;
			finished_q <= 1'b0;
		end else begin
			if (cmd.take && restart) begin
				gen_q      <= 31'(seed_q);
				produced_q <= '0;
				env_cnt_q  <= '0;
				finished_q <= 1'b0;
			end
			if (cmd.gen1 || cmd.gen2 || cmd.gen3) begin
				gen_q <= gen_next;
			end
			if (cmd.decide) begin
				env_cnt_q <= env_next;
				if (accept) begin
					produced_q <= prod_next;
					if (last_now) begin
						finished_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.decide && accept) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	// Trial arithmetic, one multiply deep per step.
	always_ff @(posedge clk) begin
		if (cmd.gen1) begin
			g1_q <= gen_next;
		end
		if (cmd.gen2) begin
			g2_q  <= gen_next;
			mag_q <= (g1_q >= ONE_Q30) ? (g1_q - ONE_Q30) : (ONE_Q30 - g1_q);
		end
		if (cmd.gen3) begin
			sq_q <= 62'(mag_q) * 62'(mag_q);
			dq_q <= 64'(three_v) * 64'(RECIP_10);
		end
		if (cmd.mul) begin
			x2_q  <= x2;
			x4p_q <= 62'(x2) * 62'(x2);
			y30_q <= 31'(v30) + 31'(dq_q[63:35]);
		end
		if (cmd.env) begin
			envp_q <= 63'(y30_q) * 63'(32'(ONE_Q30) + 32'(x4));
			a_q    <= a_next;
			b_q    <= b_next;
			f_q    <= 30'({x2_q, EXP_BITS'(0)});
		end
		if (cmd.interp) begin
			pass_env_q <= (envp_q <= ENV_LIMIT);
			down_q     <= (a_q >= b_q);
			ip_q       <= 61'(diff) * 61'(f_q);
		end
		if (cmd.decide && accept) begin
			sample_q  <= {~samp_raw[SAMPLE_WIDTH-1], samp_raw[SAMPLE_WIDTH-2:0]};
			last_q    <= last_now;
			env_out_q <= env_next;
		end
	end

	assign sts.run_trial = restart || !finished_q;
	assign sts.accept    = accept;
	assign sts.out_busy  = valid_q && !m_tready;

	assign m_tvalid        = valid_q;
	assign sample          = sample_q;
	assign last_sample     = last_q;
	assign envelope_trials = env_out_q;

	`GRS_ASSERT(a_env_count_monotonic,
		!(cmd.take && restart) |=> env_cnt_q >= $past(env_cnt_q),
		"envelope count went down without a restart")
	`GRS_ASSERT(a_last_sets_finished,
		(cmd.decide && accept && last_now) |=> finished_q,
		"last sample did not stop the run")
	`GRS_ASSERT(a_valid_only_from_decide,
		(valid_q && m_tready && !cmd.decide) |=> !valid_q,
		"output stayed valid after its item was taken")

endmodule

`default_nettype wire

// ----- hw/rtl/gaussian_rejection_sampler.sv -----
// ---------------------------------------------------------------------------
// Gaussian rejection sampler
// Park-Miller driven rejection sampler emitting Gaussian-shaped Q1.15 values.
// ---------------------------------------------------------------------------
//  channel  direction  fields (lowest bit first)
//  s_*      in         tdata: restart
//  m_*      out        tdata: sample, envelope_trials; tlast: last_sample
//  cfg_*    in         index 0 seed, index 1 sample_count
//
// A trial item is taken in idle, then runs three chained generator steps through
// the 31-bit modular multiply, then the x^4, envelope, interpolation and decide
// steps, and decide loads an accepted result into the result register. The next
// item is taken in the cycle after decide; one that runs no trial stays in idle.
// A result not yet taken holds the next accepted trial in its decide step.
// Reset needs no clearing pass; the exponential table is constant logic.
// ---------------------------------------------------------------------------
`default_nettype none

module gaussian_rejection_sampler
	import grs_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // [0] restart, rest zero
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,   // sample, envelope_trials
	output logic                        m_tlast,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	grs_cmd_t                cmd;
	grs_sts_t                sts;
	logic [SAMPLE_WIDTH-1:0] sample;
	logic [ENV_W-1:0]        envelope_trials;

	grs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	grs_datapath u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.restart         (s_tdata[0]),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.cmd             (cmd),
		.sts             (sts),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.sample          (sample),
		.last_sample     (m_tlast),
		.envelope_trials (envelope_trials)
	);

	assign m_tdata = OUT_TDATA_W'({envelope_trials, sample});

endmodule

`default_nettype wire
